// ===== src/itp_pkg.sv =====
// Shared constants and the queue entry type for the integer text parser.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	// Length cap of the offset counter and width of the C long type.
	localparam int MAX_LEN   = 4095;
	localparam int LONG_BITS = 64;
	localparam int CNT_W     = 12;
	localparam int COUNT_CAP = (MAX_LEN < 4095) ? MAX_LEN : 4095;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// Configuration register indexes.
	localparam logic REG_NUMBER_BASE = 1'b0;
	localparam logic REG_RESULT_KIND = 1'b1;

	// Saturation limits.
	localparam logic [63:0] UMAX_64   = {64{1'b1}};
	localparam logic [63:0] LMAX_64   = {1'b0, {63{1'b1}}};
	localparam logic [63:0] UMAX_LONG = UMAX_64 >> (64 - LONG_BITS);
	localparam logic [63:0] LMAX_LONG = UMAX_LONG >> 1;

	// Operation codes carried through the queue.
	localparam logic [1:0] OP_ACC     = 2'd0;
	localparam logic [1:0] OP_EMIT    = 2'd1;
	localparam logic [1:0] OP_BADBASE = 2'd2;

	typedef struct packed {
		logic [1:0]       code;
		logic [5:0]       digit;
		logic [5:0]       radix;
		logic             first;
		logic             neg;
		logic             seen;
		logic             has_acc;
		logic [CNT_W-1:0] count;
	} itp_op_t;

endpackage

`default_nettype wire

// ===== src/itp_if.sv =====
// Channel interfaces: character input and parse result output.
`timescale 1ns / 1ps
`default_nettype none

interface itp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       first_char;

	modport source (output valid, output char_code, output first_char, input ready);
	modport sink   (input valid, input char_code, input first_char, output ready);
endinterface

interface itp_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] parsed_value;
	logic [11:0] end_offset;
	logic        range_error;
	logic        base_error;

	modport source (output valid, output parsed_value, output end_offset,
		output range_error, output base_error, input ready);
	modport sink   (input valid, input parsed_value, input end_offset,
		input range_error, input base_error, output ready);
endinterface

`default_nettype wire

// ===== src/itp_front.sv =====
// Front end: classifies characters, tracks the parse phase and issues queue operations.
`timescale 1ns / 1ps
`default_nettype none

module itp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      char_code,
	input  wire logic            first_char,
	input  wire logic [5:0]      number_base,
	output logic                 push,
	output itp_pkg::itp_op_t     push_op
);
	import itp_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	logic [2:0]       phase_q, phase_cur, phase_n;
	logic             neg_q, neg_cur, neg_n;
	logic             seen_q, seen_cur, seen_n;
	logic             acc_q, acc_cur, acc_n;
	logic [5:0]       radix_q, radix_cur, radix_n;
	logic [CNT_W-1:0] cnt_q, cnt_cur, cnt_n, cnt_inc;

	logic       is_space, is_sign, is_zero, is_x, bad_base;
	logic       dig_ok;
	logic [5:0] dig_val;
	logic       go_body, go_digit, seen_step;
	logic [5:0] step_radix;
	logic       push_c;
	itp_op_t    op_c;

	always_comb begin
		dig_ok  = 1'b1;
		dig_val = 6'd0;
		if (char_code >= "0" && char_code <= "9") begin
			dig_val = 6'(char_code - "0");
		end else if (char_code >= "a" && char_code <= "z") begin
			dig_val = 6'(char_code - "a") + 6'd10;
		end else if (char_code >= "A" && char_code <= "Z") begin
			dig_val = 6'(char_code - "A") + 6'd10;
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign is_space = (char_code >= 8'd9 && char_code <= 8'd13) || char_code == " ";
	assign is_sign  = char_code == "+" || char_code == "-";
	assign is_zero  = char_code == "0";
	assign is_x     = char_code == "x" || char_code == "X";
	assign bad_base = number_base == 6'd1 || number_base > 6'd36;

	always_comb begin
		// A first character restarts the string before it is classified.
		phase_cur = first_char ? PH_SPACE : phase_q;
		neg_cur   = first_char ? 1'b0 : neg_q;
		seen_cur  = first_char ? 1'b0 : seen_q;
		acc_cur   = first_char ? 1'b0 : acc_q;
		radix_cur = first_char ? 6'd0 : radix_q;
		cnt_cur   = first_char ? '0 : cnt_q;
		cnt_inc   = (cnt_cur < CNT_W'(COUNT_CAP)) ? cnt_cur + 1'b1 : cnt_cur;

		phase_n    = phase_cur;
		neg_n      = neg_cur;
		seen_n     = seen_cur;
		acc_n      = acc_cur;
		radix_n    = radix_cur;
		cnt_n      = cnt_cur;
		go_body    = 1'b0;
		go_digit   = 1'b0;
		seen_step  = seen_cur;
		step_radix = radix_cur;
		push_c     = 1'b0;
		op_c       = '0;

		case (phase_cur)
			PH_SPACE: begin
				if (is_space) begin
					cnt_n = cnt_inc;
				end else if (is_sign) begin
					neg_n   = char_code == "-";
					phase_n = PH_SIGNED;
					cnt_n   = cnt_inc;
				end else begin
					go_body = 1'b1;
				end
			end
			PH_SIGNED: go_body = 1'b1;
			PH_ZERO: begin
				phase_n = PH_DIGITS;
				if (is_x) begin
					radix_n = 6'd16;
					cnt_n   = cnt_inc;
				end else begin
					step_radix = (radix_cur == 6'd0) ? 6'd8 : 6'd16;
					radix_n    = step_radix;
					seen_step  = 1'b1;
					go_digit   = 1'b1;
				end
			end
			PH_DIGITS: go_digit = 1'b1;
			default: ;
		endcase

		if (go_body) begin
			if (bad_base) begin
				push_c       = 1'b1;
				op_c.code    = OP_BADBASE;
				phase_n      = PH_IDLE;
			end else if ((number_base == 6'd0 || number_base == 6'd16) && is_zero) begin
				radix_n = number_base;
				phase_n = PH_ZERO;
				cnt_n   = cnt_inc;
			end else begin
				step_radix = (number_base == 6'd0) ? 6'd10 : number_base;
				radix_n    = step_radix;
				phase_n    = PH_DIGITS;
				go_digit   = 1'b1;
			end
		end

		if (go_digit) begin
			push_c       = 1'b1;
			op_c.neg     = neg_cur;
			op_c.seen    = seen_step;
			op_c.has_acc = acc_cur;
			op_c.count   = cnt_cur;
			op_c.radix   = step_radix;
			op_c.digit   = dig_val;
			op_c.first   = !acc_cur;
			if (!dig_ok || dig_val >= step_radix) begin
				op_c.code = OP_EMIT;
				phase_n   = PH_IDLE;
			end else begin
				op_c.code = OP_ACC;
				acc_n     = 1'b1;
				seen_n    = 1'b1;
				cnt_n     = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			acc_q   <= 1'b0;
			radix_q <= 6'd0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			seen_q  <= seen_n;
			acc_q   <= acc_n;
			radix_q <= radix_n;
			cnt_q   <= cnt_n;
		end
	end

	assign push    = accept && push_c;
	assign push_op = op_c;

endmodule

`default_nettype wire

// ===== src/itp_queue.sv =====
// Short operation queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module itp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire itp_pkg::itp_op_t push_op,
	output logic                  full,
	input  wire logic             pop,
	output logic                  pop_valid,
	output itp_pkg::itp_op_t      pop_op
);
	import itp_pkg::*;

	itp_op_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     cnt_q;
	logic                  do_pop;

	assign full      = cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_op    = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== src/itp_back.sv =====
// Back end: digit accumulation with overflow tracking, saturation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module itp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       result_kind,
	input  wire logic             op_valid,
	input  wire itp_pkg::itp_op_t op,
	output logic                  op_pop,
	itp_result_if.source          result_out
);
	import itp_pkg::*;

	logic [63:0] acc_q;
	logic        ovf_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [11:0] offset_q;
	logic        range_q;
	logic        base_q;

	logic [63:0] acc_base;
	logic        ovf_base;
	logic [69:0] prod;
	logic [63:0] mag, neg_mag, signed_mag, lmax, lim, umax, value_c;
	logic        ovf, range_c;
	logic        is_result;

	assign is_result = op.code != OP_ACC;
	assign op_pop    = op_valid && (!is_result || !out_valid_q || result_out.ready);

	// Multiply-add in 70 bits; any carry above bit 63 is an overflow.
	always_comb begin
		acc_base = op.first ? 64'd0 : acc_q;
		ovf_base = op.first ? 1'b0 : ovf_q;
		prod     = 70'(acc_base) * 70'(op.radix) + 70'(op.digit);
	end

	always_comb begin
		mag        = op.has_acc ? acc_q : 64'd0;
		ovf        = op.has_acc && ovf_q;
		neg_mag    = 64'd0 - mag;
		signed_mag = op.neg ? neg_mag : mag;
		lmax       = result_kind[1] ? LMAX_LONG : LMAX_64;
		umax       = result_kind[1] ? UMAX_LONG : UMAX_64;
		lim        = op.neg ? lmax + 64'd1 : lmax;
		if (result_kind[0]) begin
			range_c = ovf || mag > lim;
			value_c = range_c ? (op.neg ? ~lmax : lmax) : signed_mag;
		end else begin
			range_c = ovf || mag > umax;
			value_c = range_c ? umax : (signed_mag & umax);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 64'd0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_pop && !is_result) begin
				if (ovf_base || prod[69:64] != 6'd0) begin
					acc_q <= UMAX_64;
					ovf_q <= 1'b1;
				end else begin
					acc_q <= prod[63:0];
					ovf_q <= 1'b0;
				end
			end
			if (op_pop && is_result) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && is_result) begin
			case (op.code)
				OP_EMIT: begin
					value_q  <= value_c;
					offset_q <= op.seen ? op.count : 12'd0;
					range_q  <= range_c;
					base_q   <= 1'b0;
				end
				default: begin
					value_q  <= 64'd0;
					offset_q <= 12'd0;
					range_q  <= 1'b0;
					base_q   <= 1'b1;
				end
			endcase
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.parsed_value = value_q;
	assign result_out.end_offset   = offset_q;
	assign result_out.range_error  = range_q;
	assign result_out.base_error   = base_q;

	a_ovf_sticks_ones: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> acc_q == UMAX_64)
		else $error("overflow set but accumulator not saturated");

	a_bad_base_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && base_q) |-> (value_q == 64'd0 && offset_q == 12'd0 && !range_q))
		else $error("bad-base beat carries a value");

endmodule

`default_nettype wire

// ===== src/integer_text_parser.sv =====
// Top level of the streaming string-to-integer parser with its register port.
//
//  channel     dir  handshake      beat contents
//  char_in     in   valid/ready    char_code[7:0], first_char
//  result_out  out  valid/ready    parsed_value[63:0], end_offset[11:0], range_error, base_error
//  apb         in   psel/penable   number_base at 0x0, result_kind at 0x4
//
// One character beat is taken every cycle while the operation queue is not full; the 64x6
// multiply-add in the back end sets that rate. A result passes through the operation
// queue and then the result register after the character that ends it is taken.
// char_in.ready drops only when the four-entry operation queue is full, which happens
// only while a finished result waits on result_out.ready.
// Reset is asynchronous and immediate; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_text_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	itp_char_if.sink         char_in,
	itp_result_if.source     result_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import itp_pkg::*;

	logic [5:0] number_base_q;
	logic [1:0] result_kind_q;
	logic       reg_write;

	logic       full, push, pop, pop_valid, accept;
	itp_op_t    push_op, pop_op;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= 6'd10;
			result_kind_q <= 2'd1;
		end else if (reg_write) begin
			case (paddr[2])
				REG_NUMBER_BASE: number_base_q <= pwdata[5:0];
				REG_RESULT_KIND: result_kind_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_RESULT_KIND) ? {30'd0, result_kind_q}
		: {26'd0, number_base_q};

	assign char_in.ready = !full;
	assign accept        = char_in.valid && !full;

	itp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (char_in.char_code),
		.first_char  (char_in.first_char),
		.number_base (number_base_q),
		.push        (push),
		.push_op     (push_op)
	);

	itp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_op    (pop_op)
	);

	itp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.result_kind (result_kind_q),
		.op_valid    (pop_valid),
		.op          (pop_op),
		.op_pop      (pop),
		.result_out  (result_out)
	);

endmodule

`default_nettype wire

// ===== verif/integer_text_parser_test.sv =====
// Self-checking regression for the streaming string-to-integer parser.
`timescale 1ns / 1ps

module integer_text_parser_test;
	import itp_pkg::*;

	localparam int STALL_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int LONG_HOLD       = 300;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int PRESSURE_PHASE  = 2;

	localparam int BASE_MAX = 36;
	localparam int BASE_DEC = 10;
	localparam int BASE_HEX = 16;
	localparam int BASE_OCT = 8;

	localparam logic [1:0] KIND_U64   = 2'd0;
	localparam logic [1:0] KIND_S64   = 2'd1;
	localparam logic [1:0] KIND_ULONG = 2'd2;
	localparam logic [1:0] KIND_SLONG = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_A_LO  = "a";
	localparam logic [7:0] CH_Z_LO  = "z";
	localparam logic [7:0] CH_A_UP  = "A";
	localparam logic [7:0] CH_Z_UP  = "Z";
	localparam logic [7:0] CH_X_LO  = "x";
	localparam logic [7:0] CH_X_UP  = "X";

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SPACE  = 3'd1;
	localparam logic [2:0] ST_SIGNED = 3'd2;
	localparam logic [2:0] ST_ZERO   = 3'd3;
	localparam logic [2:0] ST_DIGITS = 3'd4;

	typedef struct packed {
		logic [63:0] value;
		logic [11:0] offset;
		logic        range_err;
		logic        base_err;
	} parse_result_t;

	typedef struct {
		logic [5:0]    base;
		logic [1:0]    kind;
		bit            lead;
		string         text;
		int            tail;
		bit            typed;
		parse_result_t want;
	} directed_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	itp_char_if   char_bus ();
	itp_result_if res_bus ();

	integer_text_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_bus),
		.result_out (res_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Shadow of the parser: configuration and scan state.
	logic [5:0]  cfg_base = 6'd10;
	logic [1:0]  cfg_kind = KIND_S64;
	logic [2:0]  scan_state = ST_IDLE;
	logic [63:0] acc = '0;
	logic        neg = 1'b0;
	logic        saturated = 1'b0;
	logic        have_digit = 1'b0;
	logic [5:0]  radix = '0;
	logic [11:0] count = '0;

	parse_result_t awaited_numbers [$];
	parse_result_t front_want;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	int            long_hold_cycles = 0;
	bit            source_gaps = 1'b0;
	bit            sink_stalls = 1'b0;
	bit            pressure_done = 1'b0;
	int            sent;

	logic [5:0] phase_base [PHASES] = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd8,
		6'd0, 6'd1, 6'd63, 6'd37, 6'd3, 6'd0};
	logic [1:0] phase_kind [PHASES] = '{KIND_S64, KIND_U64, KIND_SLONG, KIND_ULONG,
		KIND_SLONG, KIND_U64, KIND_ULONG, KIND_S64, KIND_U64, KIND_SLONG, KIND_S64,
		KIND_S64};

	directed_row_t directed_rows [9] = '{
		'{6'd10, KIND_S64,   1'b0, "7",     -1, 1'b0, '0},
		'{6'd10, KIND_S64,   1'b1, "\t-42",  0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFD6, 12'd4, 1'b0, 1'b0}},
		'{6'd10, KIND_S64,   1'b1, "12",    -1, 1'b0, '0},
		'{6'd10, KIND_S64,   1'b1, "+",      0, 1'b1, '{64'd0, 12'd0, 1'b0, 1'b0}},
		'{6'd0,  KIND_U64,   1'b1, "0x",     0, 1'b1, '{64'd0, 12'd0, 1'b0, 1'b0}},
		'{6'd0,  KIND_U64,   1'b1, "017z", 255, 1'b1, '{64'd15, 12'd3, 1'b0, 1'b0}},
		'{6'd1,  KIND_S64,   1'b1, "-5",    -1, 1'b1, '{64'd0, 12'd0, 1'b0, 1'b1}},
		'{6'd36, KIND_SLONG, 1'b1, "zZ",     0, 1'b0, '0},
		'{6'd2,  KIND_ULONG, 1'b1, "-1",     0, 1'b0, '0}
	};

	function automatic int digit_of(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_A_LO && c <= CH_Z_LO) return int'(c - CH_A_LO) + 10;
		if (c >= CH_A_UP && c <= CH_Z_UP) return int'(c - CH_A_UP) + 10;
		return -1;
	endfunction

	task automatic count_up();
		if (count < 12'(COUNT_CAP)) count++;
	endtask

	// Applies the saturation rule of the selected result kind and returns to idle.
	task automatic close_number(output parse_result_t r);
		logic [63:0] mag, v, llimit;
		logic        ovf, rng;
		mag = have_digit ? acc : 64'd0;
		ovf = have_digit && saturated;
		rng = 1'b0;
		llimit = neg ? ~LMAX_64 : LMAX_64;
		case (cfg_kind)
			KIND_U64: begin
				if (ovf) begin
					v = UMAX_64;
					rng = 1'b1;
				end else v = neg ? 64'd0 - mag : mag;
			end
			KIND_ULONG: begin
				if (ovf || mag > UMAX_LONG) begin
					v = UMAX_LONG;
					rng = 1'b1;
				end else v = (neg ? 64'd0 - mag : mag) & UMAX_LONG;
			end
			default: begin
				if (ovf || mag > llimit) begin
					v = llimit;
					rng = 1'b1;
				end else v = neg ? 64'd0 - mag : mag;
				if (cfg_kind == KIND_SLONG) begin
					if (!v[63]) begin
						if (v > LMAX_LONG) begin
							v = LMAX_LONG;
							rng = 1'b1;
						end
					end else if (v < ~LMAX_LONG) begin
						v = ~LMAX_LONG;
						rng = 1'b1;
					end
				end
			end
		endcase
		r = '{v, have_digit ? count : 12'd0, rng, 1'b0};
		scan_state = ST_IDLE;
	endtask

	task automatic take_digit(input logic [7:0] c, output bit made, output parse_result_t r);
		int          d;
		logic [63:0] b, cut, lim;
		d = digit_of(c);
		b = 64'(radix);
		made = 1'b0;
		r = '0;
		if (d < 0 || d >= int'(radix)) begin
			close_number(r);
			made = 1'b1;
		end else begin
			if (saturated) acc = UMAX_64;
			else begin
				cut = UMAX_64 / b;
				lim = UMAX_64 % b;
				if (acc > cut || (acc == cut && 64'(d) > lim)) begin
					saturated = 1'b1;
					acc = UMAX_64;
				end else acc = acc * b + 64'(d);
			end
			have_digit = 1'b1;
			count_up();
		end
	endtask

	// The base register is sampled here, once the sign has been passed.
	task automatic begin_body(input logic [7:0] c, output bit made, output parse_result_t r);
		made = 1'b0;
		r = '0;
		if (cfg_base == 6'd1 || int'(cfg_base) > BASE_MAX) begin
			r = '{64'd0, 12'd0, 1'b0, 1'b1};
			scan_state = ST_IDLE;
			made = 1'b1;
		end else if ((cfg_base == 6'd0 || int'(cfg_base) == BASE_HEX) && c == CH_ZERO) begin
			radix = cfg_base;
			scan_state = ST_ZERO;
			count_up();
		end else begin
			radix = (cfg_base == 6'd0) ? 6'(BASE_DEC) : cfg_base;
			scan_state = ST_DIGITS;
			take_digit(c, made, r);
		end
	endtask

	task automatic parse_byte(input logic [7:0] c, input logic first, output bit made,
			output parse_result_t r);
		made = 1'b0;
		r = '0;
		if (first) begin
			scan_state = ST_SPACE;
			acc = '0;
			neg = 1'b0;
			saturated = 1'b0;
			have_digit = 1'b0;
			radix = '0;
			count = '0;
		end
		case (scan_state)
			ST_SPACE: begin
				if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) count_up();
				else if (c == CH_PLUS || c == CH_MINUS) begin
					neg = (c == CH_MINUS);
					scan_state = ST_SIGNED;
					count_up();
				end else begin_body(c, made, r);
			end
			ST_SIGNED: begin_body(c, made, r);
			ST_ZERO: begin
				scan_state = ST_DIGITS;
				if (c == CH_X_LO || c == CH_X_UP) begin
					radix = 6'(BASE_HEX);
					count_up();
				end else begin
					// A lone leading zero is itself a digit of the number.
					radix = (radix == 6'd0) ? 6'(BASE_OCT) : 6'(BASE_HEX);
					have_digit = 1'b1;
					take_digit(c, made, r);
				end
			end
			ST_DIGITS: take_digit(c, made, r);
			default: ;
		endcase
	endtask

	task automatic offer_char(input logic [7:0] c, input logic first, input bit typed,
			input parse_result_t want);
		bit            made;
		parse_result_t r;
		@(negedge clk);
		if (source_gaps && $urandom_range(0, 5) == 0) begin
			char_bus.valid = 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 2))
				@(negedge clk);
		end
		char_bus.valid = 1'b1;
		char_bus.char_code = c;
		char_bus.first_char = first;
		@(posedge clk);
		while (!char_bus.ready) @(posedge clk);
		parse_byte(c, first, made, r);
		if (made) awaited_numbers.push_back(typed ? want : r);
	endtask

	task automatic settle();
		@(negedge clk);
		char_bus.valid = 1'b0;
		while (awaited_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_NUMBER_BASE) cfg_base = data[5:0];
		else cfg_kind = data[1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_config(input logic [5:0] base, input logic [1:0] kind);
		settle();
		write_reg(REG_NUMBER_BASE, 32'(base));
		write_reg(REG_RESULT_KIND, 32'(kind));
	endtask

	// One string: mostly well-formed numbers with random content, some raw noise.
	task automatic send_string(inout int total);
		logic [7:0]  seq [$];
		logic [7:0]  digs [$];
		logic [63:0] v;
		int          eff, n, r;
		bit          plain_auto;
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				offer_char(8'($urandom_range(0, 255)),
					(i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0),
					1'b0, '0);
			total += n;
			return;
		end
		plain_auto = 1'b0;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 5);
				seq.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
			end
		r = $urandom_range(0, 3);
		if (r == 0) seq.push_back(CH_PLUS);
		else if (r == 1) seq.push_back(CH_MINUS);
		if (cfg_base == 6'd1 || int'(cfg_base) > BASE_MAX) eff = BASE_DEC;
		else if (cfg_base == 6'd0 || int'(cfg_base) == BASE_HEX) begin
			r = $urandom_range(0, 3);
			if (r == 0) begin
				seq.push_back(CH_ZERO);
				seq.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
				eff = BASE_HEX;
			end else if (r == 1) begin
				seq.push_back(CH_ZERO);
				eff = (cfg_base == 6'd0) ? BASE_OCT : BASE_HEX;
			end else begin
				eff = (cfg_base == 6'd0) ? BASE_DEC : BASE_HEX;
				plain_auto = (cfg_base == 6'd0);
			end
		end else eff = int'(cfg_base);
		if ($urandom_range(0, 3) == 0) begin
			// Digits of a value near a saturation limit, so the cutoff test is hit.
			case ($urandom_range(0, 1))
				0: v = UMAX_64 - 64'($urandom_range(0, 2));
				default: v = LMAX_64 - 64'd1 + 64'($urandom_range(0, 3));
			endcase
			while (v != 0) begin
				digs.push_front(8'(v % 64'(eff)));
				v = v / 64'(eff);
			end
			if ($urandom_range(0, 1)) digs[digs.size() - 1] = 8'($urandom_range(0, eff - 1));
			if ($urandom_range(0, 2) == 0) digs.push_back(8'($urandom_range(0, eff - 1)));
		end else begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				digs.push_back((i == 0 && plain_auto) ? 8'($urandom_range(1, 9))
					: 8'($urandom_range(0, eff - 1)));
		end
		foreach (digs[i])
			seq.push_back((digs[i] < 8'd10) ? CH_ZERO + digs[i]
				: (($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + digs[i] - 8'd10));
		seq.push_back($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)));
		foreach (seq[i]) offer_char(seq[i], i == 0, 1'b0, '0);
		total += seq.size();
		if ($urandom_range(0, 5) == 0) offer_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_cycles > 0) begin
				res_bus.ready = 1'b0;
				repeat (long_hold_cycles - 1) @(negedge clk);
				long_hold_cycles = 0;
			end else if (stall_left > 0) begin
				res_bus.ready = 1'b0;
				stall_left--;
			end else begin
				res_bus.ready = 1'b1;
				if (sink_stalls && $urandom_range(0, 7) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready) begin
			if (awaited_numbers.size() == 0) begin
				$display("%0t: result with none awaited: value %h offset %0d range %b base %b",
					$time, res_bus.parsed_value, res_bus.end_offset, res_bus.range_error,
					res_bus.base_error);
				mismatches++;
			end else begin
				front_want = awaited_numbers.pop_front();
				if (res_bus.parsed_value !== front_want.value) begin
					$display("%0t: parsed_value expected %h, got %h", $time,
						front_want.value, res_bus.parsed_value);
					mismatches++;
				end
				if (res_bus.end_offset !== front_want.offset) begin
					$display("%0t: end_offset expected %0d, got %0d", $time,
						front_want.offset, res_bus.end_offset);
					mismatches++;
				end
				if (res_bus.range_error !== front_want.range_err) begin
					$display("%0t: range_error expected %b, got %b", $time,
						front_want.range_err, res_bus.range_error);
					mismatches++;
				end
				if (res_bus.base_error !== front_want.base_err) begin
					$display("%0t: base_error expected %b, got %b", $time,
						front_want.base_err, res_bus.base_error);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("integer_text_parser regression: fail");
		$finish;
	end

	initial begin
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		char_bus.first_char = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].base != cfg_base || directed_rows[k].kind != cfg_kind)
				set_config(directed_rows[k].base, directed_rows[k].kind);
			for (int i = 0; i < directed_rows[k].text.len(); i++)
				offer_char(directed_rows[k].text[i], directed_rows[k].lead && i == 0,
					directed_rows[k].typed, directed_rows[k].want);
			if (directed_rows[k].tail >= 0)
				offer_char(8'(directed_rows[k].tail), 1'b0, directed_rows[k].typed,
					directed_rows[k].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_config(phase_base[p], phase_kind[p]);
			source_gaps = (p != 0) && ($urandom_range(0, 3) != 0);
			sink_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// Starve the result side long enough for the block to back up its input.
				if (p == PRESSURE_PHASE && sent >= 10 && !pressure_done) begin
					long_hold_cycles = LONG_HOLD;
					pressure_done = 1'b1;
				end
				send_string(sent);
			end
			// A bare terminator closes any open string so the next write finds it idle.
			offer_char(CH_NUL, 1'b1, 1'b0, '0);
		end
		settle();

		if (mismatches == 0)
			$display("integer_text_parser regression: pass");
		else
			$display("integer_text_parser regression: fail");
		$finish;
	end

endmodule
